FILE: design/ipv4_dotted_quad_parser_macros.svh
// ----------------------------------------------------------------------------
// ipv4_dotted_quad_parser_macros.svh
// Assertion macros shared by the checker of the dotted-quad parser.
// ----------------------------------------------------------------------------
`ifndef IPV4_DOTTED_QUAD_PARSER_MACROS_SVH
`define IPV4_DOTTED_QUAD_PARSER_MACROS_SVH

// Same-cycle implication under reset.
`define DQP_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication under reset.
`define DQP_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: design/dqp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dqp_pkg
// Types and constants of the dotted-quad IPv4 address parser.
// ----------------------------------------------------------------------------
package dqp_pkg;

  localparam int unsigned OCTET_COUNT = 4;
  localparam int unsigned IDX_W       = 2;
  localparam int unsigned CNT_W       = 3;
  localparam int unsigned PROD_W      = 12;

  localparam logic [CNT_W-1:0]  OCTETS_FULL = CNT_W'(OCTET_COUNT);
  localparam logic [PROD_W-1:0] OCTET_MAX   = PROD_W'(255);
  localparam logic [PROD_W-1:0] RADIX       = PROD_W'(10);

  localparam logic [7:0] CHAR_ZERO = 8'h30;
  localparam logic [7:0] CHAR_NINE = 8'h39;
  localparam logic [7:0] CHAR_DOT  = 8'h2e;

  typedef logic [OCTET_COUNT-1:0][7:0] octet_vec_t;

  typedef struct packed {
    logic [7:0]       acc;
    logic             seen;
    logic [CNT_W-1:0] count;
    octet_vec_t       octets;
    logic             err;
  } dqp_state_t;

  typedef struct packed {
    logic       ok;
    octet_vec_t octets;
  } dqp_result_t;

  localparam dqp_state_t STATE_CLEAR = '0;

endpackage

FILE: design/dqp_step.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dqp_step
// One parse step: current state and one beat give next state and result.
// ----------------------------------------------------------------------------
module dqp_step import dqp_pkg::*; (
  input  dqp_state_t  state,
  input  logic [7:0]  char_code,
  input  logic        end_of_text,
  output dqp_state_t  state_next,
  output dqp_result_t result
);

  logic              is_digit;
  logic              is_dot;
  logic              full;
  logic [PROD_W-1:0] prod;
  dqp_state_t        stored;
  dqp_state_t        char_next;

  assign is_digit = (char_code >= CHAR_ZERO) && (char_code <= CHAR_NINE);
  assign is_dot   = (char_code == CHAR_DOT);
  assign full     = (state.count == OCTETS_FULL);
  assign prod     = PROD_W'(state.acc) * RADIX + PROD_W'(char_code[3:0]);

  // Store the pending octet into the next free slot.
  always_comb begin
    stored = state;
    if (!full) begin
      stored.octets[state.count[IDX_W-1:0]] = state.acc;
      stored.count = state.count + CNT_W'(1);
    end
    stored.acc  = '0;
    stored.seen = 1'b0;
  end

  always_comb begin
    char_next = state;
    if (!state.err && !full) begin
      if (is_digit) begin
        if (prod > OCTET_MAX) begin
          char_next.err = 1'b1;
        end else begin
          char_next.acc  = prod[7:0];
          char_next.seen = 1'b1;
        end
      end else if (is_dot) begin
        if (state.seen) begin
          char_next = stored;
        end else begin
          char_next.err = 1'b1;
        end
      end else begin
        char_next.err = 1'b1;
      end
    end
  end

  always_comb begin
    dqp_state_t fin;
    fin = (!state.err && state.seen) ? stored : state;
    result.ok     = !fin.err && (fin.count == OCTETS_FULL);
    result.octets = result.ok ? fin.octets : '0;
    state_next    = end_of_text ? STATE_CLEAR : char_next;
  end

endmodule

FILE: design/dqp_out_buf.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dqp_out_buf
// Result register with valid/ready handshake toward the consumer.
// ----------------------------------------------------------------------------
module dqp_out_buf import dqp_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        load,
  input  dqp_result_t data,
  output logic        busy,
  output logic        result_valid,
  input  logic        result_ready,
  output logic        valid_res,
  output logic [7:0]  octet_first,
  output logic [7:0]  octet_second,
  output logic [7:0]  octet_third,
  output logic [7:0]  octet_fourth
);

  logic        full;
  logic        full_next;
  dqp_result_t held;

  // Hold the slot until taken; a load may refill it in the same cycle.
  always_comb begin
    full_next = full;
    if (load) begin
      full_next = 1'b1;
    end else if (result_ready) begin
      full_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      full <= 1'b0;
    end else begin
      full <= full_next;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      held <= data;
    end
  end

  assign busy         = full && !result_ready;
  assign result_valid = full;
  assign valid_res    = held.ok;
  assign octet_first  = held.octets[0];
  assign octet_second = held.octets[1];
  assign octet_third  = held.octets[2];
  assign octet_fourth = held.octets[3];

endmodule

FILE: design/ipv4_dotted_quad_parser.sv
`timescale 1ns / 1ps
// The result of a terminator beat is registered in the result register as the beat is accepted.
// Throughput: one beat per cycle while the result register is not stalled; the parse state updates in one pass.
// The result register frees in the cycle its result is taken, so beats flow on.
// Reset (rst, synchronous, active high) clears the parse state and empties
// the result register.
// ----------------------------------------------------------------------------
// ipv4_dotted_quad_parser
// Top level: parse state register, step logic and result register.
// ----------------------------------------------------------------------------
module ipv4_dotted_quad_parser import dqp_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       item_valid,
  output logic       item_ready,
  input  logic [7:0] char_code,
  input  logic       end_of_text,
  output logic       result_valid,
  input  logic       result_ready,
  output logic       valid_res,
  output logic [7:0] octet_first,
  output logic [7:0] octet_second,
  output logic [7:0] octet_third,
  output logic [7:0] octet_fourth
);

  dqp_state_t  state;
  dqp_state_t  state_next;
  dqp_result_t step_result;
  logic        accept;
  logic        out_busy;

  // Take a beat whenever the result slot is empty or draining this cycle.
  // Character beats never need the slot, but keeping one rule keeps ready
  // independent of the payload.
  assign item_ready = !out_busy;
  assign accept     = item_valid && item_ready;

  // Combinational step: digit accumulate, range check, dot store, and the
  // terminator's final store and success check.
  dqp_step u_step (
    .state       (state),
    .char_code   (char_code),
    .end_of_text (end_of_text),
    .state_next  (state_next),
    .result      (step_result)
  );

  // Advance the parse state on every accepted beat.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= STATE_CLEAR;
    end else if (accept) begin
      state <= state_next;
    end
  end

  // Only a terminator beat produces a result.
  dqp_out_buf u_out (
    .clk          (clk),
    .rst          (rst),
    .load         (accept && end_of_text),
    .data         (step_result),
    .busy         (out_busy),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .valid_res    (valid_res),
    .octet_first  (octet_first),
    .octet_second (octet_second),
    .octet_third  (octet_third),
    .octet_fourth (octet_fourth)
  );

endmodule

FILE: design/dqp_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dqp_checker
// Port-level checks of the dotted-quad parser, bound to the top level.
// ----------------------------------------------------------------------------
`include "ipv4_dotted_quad_parser_macros.svh"

module dqp_checker (
  input logic       clk,
  input logic       rst,
  input logic       item_valid,
  input logic       item_ready,
  input logic       end_of_text,
  input logic       result_valid,
  input logic       result_ready,
  input logic       valid_res,
  input logic [7:0] octet_first,
  input logic [7:0] octet_second,
  input logic [7:0] octet_third,
  input logic [7:0] octet_fourth
);

  logic        res_stall;
  logic        res_fail;
  logic        octets_zero;
  logic        term_beat;
  logic [32:0] res_word;

  assign res_stall   = result_valid && !result_ready;
  assign res_fail    = result_valid && !valid_res;
  assign res_word    = {valid_res, octet_first, octet_second, octet_third, octet_fourth};
  assign octets_zero = (res_word[31:0] == 32'd0);
  assign term_beat   = item_valid && item_ready && end_of_text;

  `DQP_ASSERT_NEXT(a_hold, clk, rst, res_stall, result_valid && $stable(res_word), "result moved")
  `DQP_ASSERT_IMPLY(a_fail_zero, clk, rst, res_fail, octets_zero, "failed result carries octets")
  `DQP_ASSERT_IMPLY(a_res_source, clk, rst, $rose(result_valid), $past(term_beat), "orphan result")
  `DQP_ASSERT_IMPLY(a_ready_free, clk, rst, !result_valid, item_ready, "input stalled while empty")

endmodule

bind ipv4_dotted_quad_parser dqp_checker u_dqp_checker (
  .clk          (clk),
  .rst          (rst),
  .item_valid   (item_valid),
  .item_ready   (item_ready),
  .end_of_text  (end_of_text),
  .result_valid (result_valid),
  .result_ready (result_ready),
  .valid_res    (valid_res),
  .octet_first  (octet_first),
  .octet_second (octet_second),
  .octet_third  (octet_third),
  .octet_fourth (octet_fourth)
);

FILE: tb/dqp_result_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dqp_result_checker
// Watches both channels of the dotted-quad parser. Predicts the result of
// every terminator beat and compares each result beat field by field.
// ----------------------------------------------------------------------------
module dqp_result_checker import dqp_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        item_valid,
  input  logic        item_ready,
  input  logic [7:0]  char_code,
  input  logic        end_of_text,
  input  logic        result_valid,
  input  logic        result_ready,
  input  logic        valid_res,
  input  logic [7:0]  octet_first,
  input  logic [7:0]  octet_second,
  input  logic [7:0]  octet_third,
  input  logic [7:0]  octet_fourth,
  output int unsigned fail_count,
  output int unsigned pending
);

  localparam int unsigned REPORT_MAX = 10;

  typedef struct packed {
    logic       ok;
    logic [7:0] first;
    logic [7:0] second;
    logic [7:0] third;
    logic [7:0] fourth;
  } quad_t;

  quad_t       expected_quads[$];
  int unsigned fails = 0;
  int unsigned queued = 0;

  // parse state, mirrors the block's own
  logic [7:0]       acc;
  logic             seen;
  logic [CNT_W-1:0] stored;
  logic [7:0]       octs [OCTET_COUNT];
  logic             err;

  assign fail_count = fails;
  assign pending    = queued;

  task automatic clear_parse();
    int i;
    acc    = '0;
    seen   = 1'b0;
    stored = '0;
    err    = 1'b0;
    for (i = 0; i < OCTET_COUNT; i++) octs[i] = '0;
  endtask

  task automatic close_octet();
    if (stored < OCTETS_FULL) begin
      octs[stored[IDX_W-1:0]] = acc;
      stored = stored + CNT_W'(1);
    end
    acc  = '0;
    seen = 1'b0;
  endtask

  task automatic parse_beat(input logic [7:0] ch, input logic term);
    logic [PROD_W-1:0] next_val;
    quad_t             q;
    if (!term) begin
      // drop characters after a failure or past the fourth dot
      if (!err && stored < OCTETS_FULL) begin
        if (ch >= CHAR_ZERO && ch <= CHAR_NINE) begin
          next_val = acc * RADIX + (ch - CHAR_ZERO);
          if (next_val > OCTET_MAX) begin
            err = 1'b1;
          end else begin
            acc  = next_val[7:0];
            seen = 1'b1;
          end
        end else if (ch == CHAR_DOT) begin
          if (!seen) err = 1'b1;
          else close_octet();
        end else begin
          err = 1'b1;
        end
      end
    end else begin
      if (!err && seen && stored < OCTETS_FULL) close_octet();
      q = '0;
      if (!err && stored == OCTETS_FULL) begin
        q = '{ok: 1'b1, first: octs[0], second: octs[1], third: octs[2], fourth: octs[3]};
      end
      expected_quads.push_back(q);
      clear_parse();
    end
  endtask

  task automatic check_result();
    quad_t got;
    quad_t want;
    got = '{ok: valid_res, first: octet_first, second: octet_second,
            third: octet_third, fourth: octet_fourth};
    if (expected_quads.size() == 0) begin
      if (fails < REPORT_MAX)
        $display("%0t: unexpected result ok=%0b %0d.%0d.%0d.%0d", $realtime,
                 got.ok, got.first, got.second, got.third, got.fourth);
      fails++;
    end else begin
      want = expected_quads.pop_front();
      if (got.ok !== want.ok || got.first !== want.first || got.second !== want.second ||
          got.third !== want.third || got.fourth !== want.fourth) begin
        if (fails < REPORT_MAX)
          $display("%0t: mismatch expected ok=%0b %0d.%0d.%0d.%0d got ok=%0b %0d.%0d.%0d.%0d",
                   $realtime, want.ok, want.first, want.second, want.third, want.fourth,
                   got.ok, got.first, got.second, got.third, got.fourth);
        fails++;
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      clear_parse();
    end else begin
      // a result beat always belongs to a terminator taken at an earlier edge
      if (result_valid && result_ready) check_result();
      if (item_valid && item_ready) parse_beat(char_code, end_of_text);
    end
    queued = expected_quads.size();
  end

endmodule

FILE: tb/ipv4_dotted_quad_parser_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipv4_dotted_quad_parser_tb
// Drives texts into the dotted-quad parser, one character beat at a time
// with a terminator beat at the end, and takes its results with random
// stalls. A checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module ipv4_dotted_quad_parser_tb import dqp_pkg::*;;

  localparam int unsigned QUIET_LIMIT  = 2000; // cycles with no beat moving
  localparam int unsigned HOLD_CYCLES  = 80;   // long receiver hold-off
  localparam int unsigned TAIL_CYCLES  = 10;
  localparam int unsigned BEAT_TARGET  = 600;

  logic       clk          = 1'b0;
  logic       rst          = 1'b1;
  logic       item_valid   = 1'b0;
  logic       item_ready;
  logic [7:0] char_code    = '0;
  logic       end_of_text  = 1'b0;
  logic       result_valid;
  logic       result_ready = 1'b0;
  logic       valid_res;
  logic [7:0] octet_first;
  logic [7:0] octet_second;
  logic [7:0] octet_third;
  logic [7:0] octet_fourth;

  int unsigned fail_count;
  int unsigned pending;

  // used by the sender, the result sink and the watchdog
  bit          tx_calm  = 1'b0; // sender offers back to back
  bit          rx_calm  = 1'b0; // receiver takes back to back
  bit          hold_req = 1'b0; // ask the sink for one long hold-off
  int unsigned burst_texts = 0;
  int unsigned beats_sent  = 0;
  int unsigned quiet_cycles = 0;

  logic [7:0] text_q[$];

  always begin
    clk = 1'b1;
    #2;
    clk = 1'b0;
    #2;
  end

  ipv4_dotted_quad_parser dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .char_code    (char_code),
    .end_of_text  (end_of_text),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .valid_res    (valid_res),
    .octet_first  (octet_first),
    .octet_second (octet_second),
    .octet_third  (octet_third),
    .octet_fourth (octet_fourth)
  );

  dqp_result_checker checker_i (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .char_code    (char_code),
    .end_of_text  (end_of_text),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .valid_res    (valid_res),
    .octet_first  (octet_first),
    .octet_second (octet_second),
    .octet_third  (octet_third),
    .octet_fourth (octet_fourth),
    .fail_count   (fail_count),
    .pending      (pending)
  );

  // Watchdog: end the run once no beat has moved on either side for too long.
  always @(posedge clk) begin
    if (rst || (item_valid && item_ready) || (result_valid && result_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("FAIL");
        $finish;
      end
    end
  end

  // Result sink: draw a stall per result beat, honor a hold-off request,
  // then hold ready high until a result beat is taken.
  initial begin : result_sink
    int unsigned stall;
    forever begin
      if ($urandom_range(0, 5) == 0) rx_calm = !rx_calm;
      stall = rx_calm ? 0 : $urandom_range(0, 9);
      if (hold_req) begin
        hold_req = 1'b0;
        stall    = HOLD_CYCLES;
      end
      // lower ready only when there is a stall, so it never drops and rises
      // within one step
      if (stall > 0) begin
        result_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      result_ready <= 1'b1;
      do @(posedge clk); while (!result_valid || rst);
    end
  end

  // Offer one beat after a random gap and hold it until it is taken.
  // Keep valid high across back-to-back beats; drop it only for a gap.
  task automatic send_beat(input logic [7:0] ch, input logic term);
    int unsigned gap;
    gap = tx_calm ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_valid  <= 1'b1;
    char_code   <= ch;
    end_of_text <= term;
    do @(posedge clk); while (!item_ready);
    beats_sent++;
  endtask

  // Send the queued text and a terminator; the terminator carries random
  // character bits, which the block must ignore.
  task automatic send_text();
    int i;
    if (burst_texts > 0) begin
      tx_calm = 1'b1;
      burst_texts--;
    end else if ($urandom_range(0, 7) == 0) begin
      tx_calm = !tx_calm;
    end
    for (i = 0; i < text_q.size(); i++) send_beat(text_q[i], 1'b0);
    send_beat(8'($urandom_range(0, 255)), 1'b1);
    text_q.delete();
  endtask

  // Drop valid and wait until every outstanding result has come back.
  // Sample the count at the falling edge, away from the checker's update.
  task automatic drain();
    item_valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    @(posedge clk);
  endtask

  task automatic add_str(input string s);
    int i;
    for (i = 0; i < s.len(); i++) text_q.push_back(s[i]);
  endtask

  // Octet values lean toward the edges of the legal range.
  function automatic int unsigned pick_octet();
    case ($urandom_range(0, 7))
      0:       return 0;
      1:       return 255;
      2:       return $urandom_range(0, 9);
      3:       return $urandom_range(250, 255);
      default: return $urandom_range(0, 255);
    endcase
  endfunction

  task automatic add_address(input int unsigned n);
    int unsigned k;
    for (k = 0; k < n; k++) begin
      if (k > 0) text_q.push_back(CHAR_DOT);
      // leading zeros now and then
      if ($urandom_range(0, 3) == 0) repeat ($urandom_range(1, 2)) text_q.push_back(CHAR_ZERO);
      add_str($sformatf("%0d", pick_octet()));
    end
  endtask

  // Noise leans toward digits and dots so that it reaches past the first state.
  function automatic logic [7:0] pick_char();
    case ($urandom_range(0, 3))
      0:       return CHAR_ZERO + 8'($urandom_range(0, 9));
      1:       return CHAR_DOT;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic add_random_text();
    int unsigned pos;
    case ($urandom_range(0, 15))
      0, 1, 2, 3, 4, 5, 6, 7, 8: begin
        add_address(4);
        // trailing text after a fourth dot is ignored
        if ($urandom_range(0, 3) == 0) begin
          text_q.push_back(CHAR_DOT);
          repeat ($urandom_range(0, 4)) text_q.push_back(8'($urandom_range(0, 255)));
        end
      end
      9, 10: begin
        // break a good address: overwrite one character or double a dot
        add_address(4);
        pos = $urandom_range(0, text_q.size() - 1);
        if ($urandom_range(0, 1) == 0) text_q[pos] = pick_char();
        else text_q.insert(pos, CHAR_DOT);
      end
      11: begin
        // an octet past 255
        add_address($urandom_range(0, 3));
        if (text_q.size() > 0) text_q.push_back(CHAR_DOT);
        add_str($sformatf("%0d", $urandom_range(256, 999)));
        if ($urandom_range(0, 1) == 0) add_str(".1.2");
      end
      12: begin
        // too few octets, sometimes with a dangling dot
        add_address($urandom_range(1, 3));
        if ($urandom_range(0, 1) == 0) text_q.push_back(CHAR_DOT);
      end
      13: add_address($urandom_range(5, 6));
      14: repeat ($urandom_range(0, 8)) text_q.push_back(pick_char());
      default: begin
        // leading dot
        text_q.push_back(CHAR_DOT);
        if ($urandom_range(0, 1) == 0) add_address(4);
      end
    endcase
  endtask

  initial begin : stimulus
    int unsigned text_idx;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Directed texts: extreme octets, empty text, overflow, dot with no
    // digit, NUL character, trailing text, too few octets, and a failure
    // that must stick through an otherwise good address.
    add_str("255.0.255.0");
    send_text();
    send_text();
    add_str("256");
    send_text();
    add_str(".");
    send_text();
    text_q.push_back(8'h00);
    send_text();
    add_str("9.9.9.9.x");
    text_q.push_back(8'hff);
    send_text();
    add_str("1.2");
    send_text();
    add_str("x1.2.3.4");
    send_text();
    drain();

    text_idx = 0;
    while (beats_sent < BEAT_TARGET) begin
      if (text_idx == 15) begin
        // hold off the sink while the sender streams, so the block backs up
        hold_req    = 1'b1;
        burst_texts = 4;
      end
      if (text_idx == 35) drain();
      add_random_text();
      send_text();
      text_idx++;
    end

    drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    @(negedge clk);
    if (fail_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

FILE: files.f
+incdir+design
design/dqp_pkg.sv
design/dqp_step.sv
design/dqp_out_buf.sv
design/ipv4_dotted_quad_parser.sv
design/dqp_checker.sv
tb/dqp_result_checker.sv
tb/ipv4_dotted_quad_parser_tb.sv
